// ===== rtl/bleuc_pkg.sv =====
package bleuc_pkg;

    localparam int TableDepth = 30;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    localparam logic [15:0] CodeClass1 = 16'h3082;
    localparam logic [15:0] CodeClass2 = 16'h3081;
    localparam logic [15:0] CodeClass3 = 16'h3083;

    localparam logic [7:0] TypeList16A  = 8'h02;
    localparam logic [7:0] TypeList16B  = 8'h03;
    localparam logic [7:0] TypeList32A  = 8'h04;
    localparam logic [7:0] TypeList32B  = 8'h05;
    localparam logic [7:0] TypeList128A = 8'h06;
    localparam logic [7:0] TypeList128B = 8'h07;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_TWO  = 2'd2,
        CLS_THREE = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_UPDATED = 2'd1,
        ST_INSERTED = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_RESULT = 2'd2
    } t_state;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [7:0]  payload_length;
        logic        last_byte;
        logic [47:0] device_address;
        logic signed [7:0] signal_strength;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] device_class;
        logic [1:0] entry_status;
        logic [4:0] entry_index;
        logic [4:0] entry_count;
    } t_out_beat;

    // search token passed along the cell chain
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [47:0] addr;
        logic [IdxW-1:0] hit_idx;
    } t_token;

endpackage

// ===== rtl/bleuc_parser.sv =====
module bleuc_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_end,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_plen,
    output bleuc_pkg::t_class     o_class
);
    import bleuc_pkg::*;

    logic [7:0] r_pos, r_nhp, r_type, r_flen, r_prev;
    t_class     r_cls;
    logic       r_stop;
    logic [7:0] n_pos, n_nhp, n_type, n_flen;
    t_class     n_cls;
    logic       n_stop;
    logic [7:0] start, d;
    logic [8:0] sum;
    logic [15:0] code;
    logic       hit;

    assign o_class = r_cls;
    assign start = r_nhp - r_flen;
    assign d = r_pos - start;
    assign sum = {1'b0, r_pos} + {1'b0, i_byte};
    assign code = {i_byte, r_prev};

    // walk length-type structures
    always_comb begin
        n_pos = (r_pos == 8'hFF) ? r_pos : r_pos + 8'd1;
        n_nhp = r_nhp; n_type = r_type; n_flen = r_flen;
        n_cls = r_cls; n_stop = r_stop; hit = 1'b0;
        if (!r_stop && r_pos < i_plen) begin
            if (r_pos == r_nhp) begin
                if (i_byte == 8'd0 || sum >= {1'b0, i_plen}) begin
                    n_stop = 1'b1;
                end else begin
                    n_flen = i_byte - 8'd1;
                    n_nhp = sum[7:0] + 8'd1;
                end
            end else if (start >= 8'd1 && r_pos == start - 8'd1) begin
                n_type = i_byte;
            end else if (r_pos >= start && r_pos < r_nhp) begin
                if (r_type == TypeList16A || r_type == TypeList16B) begin
                    hit = d[0];
                end else if (r_type == TypeList32A || r_type == TypeList32B) begin
                    hit = d[1:0] == 2'd1 && ({1'b0, d} + 9'd2) < {1'b0, r_flen};
                end else if (r_type == TypeList128A || r_type == TypeList128B) begin
                    hit = d[3:0] != 4'd0
                        && ({1'b0, d[7:4], 4'd0} + 9'd15) < {1'b0, r_flen};
                end
                if (hit) begin
                    if (code == CodeClass1) begin
                        n_cls = CLS_ONE;
                    end else if (code == CodeClass3) begin
                        if (r_cls != CLS_ONE) n_cls = CLS_THREE;
                    end else if (code == CodeClass2) begin
                        if (r_cls == CLS_NONE) n_cls = CLS_TWO;
                    end
                end
                if (n_cls == CLS_ONE) n_stop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_end) begin
            r_pos <= '0; r_nhp <= '0; r_type <= '0; r_flen <= '0;
            r_prev <= '0; r_cls <= CLS_NONE; r_stop <= 1'b0;
        end else if (i_en) begin
            r_pos <= n_pos; r_nhp <= n_nhp; r_type <= n_type; r_flen <= n_flen;
            r_prev <= i_byte; r_cls <= n_cls; r_stop <= n_stop;
        end
    end
endmodule

// ===== rtl/bleuc_cell.sv =====
module bleuc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bleuc_pkg::IdxW-1:0]    i_idx,
    input  logic                          i_used,
    input  logic                          i_wr,
    input  logic [47:0]                   i_wr_addr,
    input  logic [7:0]                    i_wr_rssi,
    input  logic                          i_wr_cls_en,
    input  bleuc_pkg::t_class             i_wr_cls,
    input  bleuc_pkg::t_token             i_tok,
    output bleuc_pkg::t_token             o_tok
);
    import bleuc_pkg::*;

    logic [47:0] r_addr;
    logic [7:0]  r_rssi;
    t_class      r_cls;
    t_token      r_tok;
    t_token      n_tok;

    assign o_tok = r_tok;

    // store one table entry
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_addr <= i_wr_addr;
            r_rssi <= i_wr_rssi;
            if (i_wr_cls_en) r_cls <= i_wr_cls;
        end
    end

    // compare against this entry; first hit wins
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && i_used && r_addr == i_tok.addr) begin
            n_tok.hit = 1'b1;
            n_tok.hit_idx = i_idx;
        end
    end

    // hand token to next cell; drop stale tokens at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end
endmodule

// ===== rtl/ble_adv_uuid_classifier_table_top.sv =====
// BLE advertising UUID classifier with seen-device table.
// Input channel: one beat per payload byte (op 0) or a table clear (op 1).
// Output channel: one beat per op 0 beat with last_byte set.
// Non-last bytes and clears are taken without a stall. A last byte starts
// a search token on the next cycle that passes down a chain of TableDepth
// entry cells, one cell per cycle; the result beat is registered from the
// chain end, and the chain length sets the per-advertisement time. From
// the search until the result beat is taken, o_stall holds off new beats.
// The table is empty after reset and after a clear.
// While a result waits on i_stall no new beat is accepted.
module ble_adv_uuid_classifier_table_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  bleuc_pkg::t_in_beat    i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output bleuc_pkg::t_out_beat   o_data
);
    import bleuc_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0] r_used;
    logic [IdxW:0] r_cnt;
    t_class cls;
    t_token tok_in;
    t_token toks [TableDepth+1];
    logic [47:0] r_addr;
    logic [7:0]  r_rssi;
    t_class      r_cls;
    t_out_beat   r_out;
    logic acc, pkt_end, wr_any, wr_cls;
    logic [IdxW-1:0] wr_idx;
    t_token fin;

    assign o_stall = r_state != S_IDLE;
    assign acc = i_valid && !o_stall;
    assign pkt_end = acc && !i_data.op && i_data.last_byte;

    bleuc_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_en(acc && !i_data.op), .i_end(r_state == S_SEARCH && r_cnt == '0),
        .i_byte(i_data.data_byte), .i_plen(i_data.payload_length),
        .o_class(cls)
    );

    // launch token in the cycle after the last byte, when the parser has folded it in
    assign tok_in.valid = r_state == S_SEARCH && r_cnt == '0;
    assign tok_in.hit = 1'b0;
    assign tok_in.addr = r_addr;
    assign tok_in.hit_idx = '0;
    assign toks[0] = tok_in;
    assign fin = toks[TableDepth];

    // write on final hit or insert
    always_comb begin
        wr_any = 1'b0; wr_cls = 1'b0; wr_idx = '0;
        if (fin.valid && r_cls != CLS_NONE) begin
            if (fin.hit) begin
                wr_any = 1'b1; wr_idx = fin.hit_idx;
            end else if (r_used < CntW'(TableDepth)) begin
                wr_any = 1'b1; wr_cls = 1'b1; wr_idx = r_used[IdxW-1:0];
            end
        end
    end

    for (genvar g = 0; g < TableDepth; g++) begin : g_cell
        bleuc_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_idx(IdxW'(g)), .i_used(CntW'(g) < r_used),
            .i_wr(wr_any && wr_idx == IdxW'(g)), .i_wr_addr(r_addr),
            .i_wr_rssi(r_rssi), .i_wr_cls_en(wr_cls), .i_wr_cls(r_cls),
            .i_tok(toks[g]), .o_tok(toks[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (pkt_end) n_state = S_SEARCH;
            S_SEARCH: if (fin.valid) n_state = S_RESULT;
            S_RESULT: if (!i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_valid = r_state == S_RESULT;
        o_data = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (acc && i_data.op) r_used <= '0;
            if (wr_cls) r_used <= r_used + 1'b1;
            if (pkt_end) r_cnt <= '0;
            else if (r_state == S_SEARCH && r_cnt == '0) r_cnt <= r_cnt + 1'b1;
        end
    end

    // capture packet and result payload
    always_ff @(posedge i_clk) begin
        if (pkt_end) begin
            r_addr <= i_data.device_address;
            r_rssi <= i_data.signal_strength;
        end
        if (tok_in.valid) r_cls <= cls;
        if (fin.valid && r_state == S_SEARCH) begin
            r_out.device_class <= r_cls;
            r_out.entry_status <= ST_NONE;
            r_out.entry_index <= '0;
            r_out.entry_count <= 5'(r_used);
            if (r_cls != CLS_NONE) begin
                if (fin.hit) begin
                    r_out.entry_status <= ST_UPDATED;
                    r_out.entry_index <= 5'(fin.hit_idx);
                end else if (wr_cls) begin
                    r_out.entry_status <= ST_INSERTED;
                    r_out.entry_index <= 5'(r_used);
                    r_out.entry_count <= 5'(r_used + 1'b1);
                end else begin
                    r_out.entry_status <= ST_DROPPED;
                end
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CntW'(TableDepth)) else $error("table count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("accept while busy");
    a_status_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.entry_status == ST_NONE || o_data.entry_status == ST_DROPPED)
        |-> o_data.entry_index == '0) else $error("index without entry");
    a_class_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.device_class == CLS_NONE |-> o_data.entry_status == ST_NONE)
        else $error("status on unclassified");
endmodule
